// ----- design/chunked_transfer_decoder_defines.svh -----
// Assertion macros used by the chunked transfer decoder parser module.
`ifndef CHUNKED_TRANSFER_DECODER_DEFINES_SVH
`define CHUNKED_TRANSFER_DECODER_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define CTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define CTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ctd_pkg.sv -----
// Types, codes and helper functions for the chunked transfer decoder.
package ctd_pkg;

  localparam int BYTE_W     = 8;
  localparam int HDR_LEN_W  = 11;
  localparam int TRL_LEN_W  = 16;
  localparam int ERR_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PASSTHROUGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEADER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRAILER = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_LINE_LONG   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_SIZE_LARGE  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_HEADER  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_TERM    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_EXCESS      = 3'd5;
  localparam logic [ERR_W-1:0] ERR_TRAILER_LONG = 3'd6;

  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;

  localparam logic [HDR_LEN_W-1:0] MAX_HEADER_RESET  = 11'd1024;
  localparam logic [TRL_LEN_W-1:0] MAX_TRAILER_RESET = 16'd8192;

  typedef struct packed {
    logic                 passthrough_mode;
    logic [HDR_LEN_W-1:0] max_header_line;
    logic [TRL_LEN_W-1:0] max_trailer_bytes;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              body_done;
    logic [ERR_W-1:0]  error_code;
    logic              block_end_out;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- design/ctd_stream_if.sv -----
// Input word channel carrying body bytes and block markers.
interface ctd_stream_if;
  logic                        valid;
  logic                        ready;
  logic [ctd_pkg::BYTE_W-1:0]  in_byte;
  logic                        block_end;

  modport source (output valid, output in_byte, output block_end, input ready);
  modport sink (input valid, input in_byte, input block_end, output ready);
endinterface

// ----- design/ctd_result_if.sv -----
// Output word channel carrying one decoder result per input byte.
interface ctd_result_if;
  logic                        valid;
  logic                        ready;
  logic [ctd_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_valid;
  logic                        body_done;
  logic [ctd_pkg::ERR_W-1:0]   error_code;
  logic                        block_end_out;

  modport source (output valid, output out_byte, output out_valid, output body_done,
                  output error_code, output block_end_out, input ready);
  modport sink (input valid, input out_byte, input out_valid, input body_done,
                input error_code, input block_end_out, output ready);
endinterface

// ----- design/ctd_cfg_if.sv -----
// Configuration write channel carrying a register index and write data.
interface ctd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ctd_pkg::CFG_IDX_W-1:0]   index;
  logic [ctd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/ctd_parser.sv -----
// Chunk framing parser: state registers and the per-byte decode logic.
`include "chunked_transfer_decoder_defines.svh"

module ctd_parser #(
  parameter int SIZE_BITS = 60
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [ctd_pkg::BYTE_W-1:0] in_byte,
  input  logic                       block_end,
  input  ctd_pkg::cfg_t              cfg,
  output ctd_pkg::res_t              res
);
  import ctd_pkg::*;

  localparam logic [3:0] PH_SIZE  = 4'd0;
  localparam logic [3:0] PH_WS    = 4'd1;
  localparam logic [3:0] PH_EXT   = 4'd2;
  localparam logic [3:0] PH_LF    = 4'd3;
  localparam logic [3:0] PH_DATA  = 4'd4;
  localparam logic [3:0] PH_DCR   = 4'd5;
  localparam logic [3:0] PH_DLF   = 4'd6;
  localparam logic [3:0] PH_TRAIL = 4'd7;
  localparam logic [3:0] PH_DONE  = 4'd8;

  logic [3:0]           phase, phase_next;
  logic [SIZE_BITS-1:0] chunk_remaining, chunk_remaining_next;
  logic [HDR_LEN_W-1:0] line_length, line_length_next;
  logic                 digit_seen, digit_seen_next;
  logic [TRL_LEN_W-1:0] trailer_count, trailer_count_next;
  logic [1:0]           blank_line_match, blank_line_match_next;
  logic [ERR_W-1:0]     sticky_error, sticky_error_next;

  logic [ERR_W-1:0]     err;
  logic                 payload;
  logic                 forward;
  logic [HDR_LEN_W:0]   line_inc;
  logic [TRL_LEN_W:0]   trl_inc;
  logic [SIZE_BITS-1:0] chunk_dec;
  logic                 is_ws;
  hex_t                 hex;

  logic [3:0]           c_phase;
  logic [SIZE_BITS-1:0] c_chunk;
  logic [HDR_LEN_W-1:0] c_line;
  logic                 c_digit;
  logic [TRL_LEN_W-1:0] c_trl;
  logic [1:0]           c_blank;

  always_comb begin
    line_inc  = {1'b0, line_length} + {{HDR_LEN_W{1'b0}}, 1'b1};
    trl_inc   = {1'b0, trailer_count} + {{TRL_LEN_W{1'b0}}, 1'b1};
    chunk_dec = chunk_remaining - {{(SIZE_BITS-1){1'b0}}, 1'b1};
    is_ws     = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB);
    hex       = hex_decode(in_byte);

    err     = ERR_NONE;
    payload = 1'b0;
    c_phase = phase;
    c_chunk = chunk_remaining;
    c_line  = line_length;
    c_digit = digit_seen;
    c_trl   = trailer_count;
    c_blank = blank_line_match;

    if ((phase <= PH_LF) && (line_inc > {1'b0, cfg.max_header_line})) begin
      err = ERR_LINE_LONG;
    end else begin
      if (phase <= PH_LF) begin
        c_line = line_inc[HDR_LEN_W-1:0];
      end
      case (phase)
        PH_SIZE: begin
          if (hex.valid) begin
            if (chunk_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
              err = ERR_SIZE_LARGE;
            end else begin
              c_chunk = {chunk_remaining[SIZE_BITS-5:0], hex.value};
              c_digit = 1'b1;
            end
          end else if (!digit_seen) begin
            err = ERR_BAD_HEADER;
          end else if (is_ws) begin
            c_phase = PH_WS;
          end else if (in_byte == CHAR_SEMI) begin
            c_phase = PH_EXT;
          end else if (in_byte == CHAR_CR) begin
            c_phase = PH_LF;
          end else begin
            err = ERR_BAD_HEADER;
          end
        end
        PH_WS: begin
          if (is_ws) begin
            c_phase = PH_WS;
          end else if (in_byte == CHAR_SEMI) begin
            c_phase = PH_EXT;
          end else if (in_byte == CHAR_CR) begin
            c_phase = PH_LF;
          end else begin
            err = ERR_BAD_HEADER;
          end
        end
        PH_EXT: begin
          if (in_byte == CHAR_LF) begin
            err = ERR_BAD_HEADER;
          end else if (in_byte == CHAR_CR) begin
            c_phase = PH_LF;
          end
        end
        PH_LF: begin
          if (in_byte != CHAR_LF) begin
            err = ERR_BAD_HEADER;
          end else begin
            c_line  = '0;
            c_digit = 1'b0;
            if (chunk_remaining == '0) begin
              c_phase = PH_TRAIL;
              c_trl   = '0;
              c_blank = 2'd2;
            end else begin
              c_phase = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          payload = 1'b1;
          c_chunk = chunk_dec;
          if (chunk_dec == '0) begin
            c_phase = PH_DCR;
          end
        end
        PH_DCR: begin
          if (in_byte != CHAR_CR) begin
            err = ERR_BAD_TERM;
          end else begin
            c_phase = PH_DLF;
          end
        end
        PH_DLF: begin
          if (in_byte != CHAR_LF) begin
            err = ERR_BAD_TERM;
          end else begin
            c_phase = PH_SIZE;
            c_chunk = '0;
            c_line  = '0;
            c_digit = 1'b0;
          end
        end
        PH_TRAIL: begin
          if (trl_inc > {1'b0, cfg.max_trailer_bytes}) begin
            err = ERR_TRAILER_LONG;
          end else begin
            c_trl = trl_inc[TRL_LEN_W-1:0];
            if ((blank_line_match == 2'd3) && (in_byte == CHAR_LF)) begin
              c_blank = 2'd0;
              c_phase = PH_DONE;
            end else if (in_byte == CHAR_CR) begin
              c_blank = (blank_line_match == 2'd2) ? 2'd3 : 2'd1;
            end else if ((in_byte == CHAR_LF) && (blank_line_match == 2'd1)) begin
              c_blank = 2'd2;
            end else begin
              c_blank = 2'd0;
            end
          end
        end
        default: begin
          err = ERR_EXCESS;
        end
      endcase
    end

    phase_next            = phase;
    chunk_remaining_next  = chunk_remaining;
    line_length_next      = line_length;
    digit_seen_next       = digit_seen;
    trailer_count_next    = trailer_count;
    blank_line_match_next = blank_line_match;
    sticky_error_next     = sticky_error;
    forward               = 1'b0;
    if (sticky_error == ERR_NONE) begin
      if (err != ERR_NONE) begin
        sticky_error_next = err;
      end else begin
        forward               = cfg.passthrough_mode || payload;
        phase_next            = c_phase;
        chunk_remaining_next  = c_chunk;
        line_length_next      = c_line;
        digit_seen_next       = c_digit;
        trailer_count_next    = c_trl;
        blank_line_match_next = c_blank;
      end
    end

    res.out_byte      = forward ? in_byte : '0;
    res.out_valid     = forward;
    res.body_done     = (phase_next == PH_DONE);
    res.error_code    = sticky_error_next;
    res.block_end_out = block_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SIZE;
      chunk_remaining  <= '0;
      line_length      <= '0;
      digit_seen       <= 1'b0;
      trailer_count    <= '0;
      blank_line_match <= 2'd0;
      sticky_error     <= ERR_NONE;
    end else if (step) begin
      phase            <= phase_next;
      chunk_remaining  <= chunk_remaining_next;
      line_length      <= line_length_next;
      digit_seen       <= digit_seen_next;
      trailer_count    <= trailer_count_next;
      blank_line_match <= blank_line_match_next;
      sticky_error     <= sticky_error_next;
    end
  end

  `CTD_ASSERT_NEXT(a_sticky_error, sticky_error != ERR_NONE, $stable(sticky_error), "error cleared")
  `CTD_ASSERT_NEXT(a_done_holds, phase == PH_DONE, phase == PH_DONE, "body done was lost")
  `CTD_ASSERT_NOW(a_data_count, phase == PH_DATA, chunk_remaining != '0, "empty data phase")
  `CTD_ASSERT_NOW(a_fwd_no_err, res.out_valid, res.error_code == ERR_NONE, "byte sent on error")

endmodule

// ----- design/chunked_transfer_decoder.sv -----
// An accepted input word's result is registered and presented in the cycle after it is accepted.
// Throughput: one word per cycle while the result side is ready; the result register frees as it is read.
// The per-byte framing decode is a single pass between state and result registers.
// Reset (rst, synchronous) clears the parser state, the sticky error and the
// result valid flag, and restores the register defaults.
module chunked_transfer_decoder #(
  parameter int SIZE_BITS = 60
) (
  input logic         clk,
  input logic         rst,
  ctd_stream_if.sink  stream,
  ctd_result_if.source result,
  ctd_cfg_if.sink     cfg
);
  import ctd_pkg::*;

  cfg_t cfg_regs;
  res_t res_comb;
  res_t res_q;
  logic res_valid;
  logic accept;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !res_valid || result.ready;
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.passthrough_mode  <= 1'b0;
      cfg_regs.max_header_line   <= MAX_HEADER_RESET;
      cfg_regs.max_trailer_bytes <= MAX_TRAILER_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PASSTHROUGH: cfg_regs.passthrough_mode  <= cfg.data[0];
        CFG_MAX_HEADER:  cfg_regs.max_header_line   <= cfg.data[HDR_LEN_W-1:0];
        CFG_MAX_TRAILER: cfg_regs.max_trailer_bytes <= cfg.data[TRL_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  ctd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .in_byte   (stream.in_byte),
    .block_end (stream.block_end),
    .cfg       (cfg_regs),
    .res       (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_comb;
    end
  end

  assign result.valid         = res_valid;
  assign result.out_byte      = res_q.out_byte;
  assign result.out_valid     = res_q.out_valid;
  assign result.body_done     = res_q.body_done;
  assign result.error_code    = res_q.error_code;
  assign result.block_end_out = res_q.block_end_out;

endmodule
